[design/mps_pkg.sv]
// Shared types, constants and arithmetic helpers for the modulated parameter smoother.
// Q2.14 widths, memory geometry, op and register codes. No dependencies.
`default_nettype none

package mps_pkg;

  localparam int VOICES      = 8;
  localparam int MODULATORS  = 8;
  localparam int MOD_ENTRIES = VOICES * MODULATORS;
  // Depth memory: per-slot depths first, then one scale entry per voice
  localparam int SCALE_BASE  = MOD_ENTRIES;
  localparam int DEP_ENTRIES = MOD_ENTRIES + VOICES;
  localparam int MOD_AW      = (MOD_ENTRIES > 1) ? $clog2(MOD_ENTRIES) : 1;
  localparam int DEP_AW      = $clog2(DEP_ENTRIES);
  localparam int CNT_W       = $clog2(DEP_ENTRIES + 1);

  localparam int Q_W     = 16;
  localparam int ALPHA_W = 15;
  localparam int PROD_W  = 2 * Q_W - 14;
  localparam int ACC_W   = PROD_W + $clog2(MODULATORS + 1);
  localparam int SPROD_W = Q_W + ALPHA_W + 2;
  localparam int STEP_W  = SPROD_W - 14;

  localparam int OP_W     = 3;
  localparam int IDX_W    = 3;
  localparam int IN_TD_W  = 24;
  localparam int OUT_TD_W = 24;
  localparam int CFG_IW   = 2;
  localparam int CFG_DW   = 16;

  localparam logic signed [Q_W-1:0] ONE_Q14 = 16'sd16384;

  localparam logic [OP_W-1:0] OP_MOD_VALUE = 3'd0;
  localparam logic [OP_W-1:0] OP_DEPTH     = 3'd1;
  localparam logic [OP_W-1:0] OP_SCALE     = 3'd2;
  localparam logic [OP_W-1:0] OP_CENTER    = 3'd3;
  localparam logic [OP_W-1:0] OP_TICK      = 3'd4;
  localparam logic [OP_W-1:0] OP_EVAL      = 3'd5;

  localparam logic [CFG_IW-1:0] CFG_ALPHA   = 2'd0;
  localparam logic [CFG_IW-1:0] CFG_BIPOLAR = 2'd1;
  localparam logic [CFG_IW-1:0] CFG_DEFAULT = 2'd2;

  typedef logic signed [Q_W-1:0] q14_t;

  typedef struct packed {
    q14_t tgt;
    q14_t cur;
  } pair_t;

  // One-pole step: cur + floor(alpha * (tgt - cur) / 2^14)
  function automatic q14_t smooth_q14(input q14_t cur, input q14_t tgt,
                                      input logic [ALPHA_W-1:0] alpha);
    logic signed [Q_W:0]       diff;
    logic signed [SPROD_W-1:0] prod;
    logic signed [STEP_W-1:0]  step;
    logic signed [STEP_W-1:0]  sum;
    diff = (Q_W+1)'(tgt) - (Q_W+1)'(cur);
    prod = $signed({1'b0, alpha}) * diff;
    step = prod[SPROD_W-1:14];
    sum  = step + STEP_W'(cur);
    return sum[Q_W-1:0];
  endfunction

  // Clamp to 0..1 or -1..1; the 16-bit saturation lies inside either range
  function automatic q14_t clamp_q14(input logic signed [ACC_W-1:0] v, input logic bipolar);
    logic signed [ACC_W-1:0] hi;
    logic signed [ACC_W-1:0] lo;
    logic signed [ACC_W-1:0] r;
    hi = ACC_W'(ONE_Q14);
    lo = bipolar ? -hi : '0;
    if (v < lo) begin
      r = lo;
    end else if (v > hi) begin
      r = hi;
    end else begin
      r = v;
    end
    return r[Q_W-1:0];
  endfunction

endpackage

`default_nettype wire

[design/modulated_parameter_smoother.sv]
// Top level of the modulated parameter smoother: memories, tick walker, evaluate datapath.
// Depends on mps_pkg for widths, codes and the smoothing and clamping helpers.
//
//   channel | direction | handshake             | payload
//   in_     | slave     | in_tvalid/in_tready   | tuser: op; tdata: voice, modulator, value
//   out_    | master    | out_tvalid/out_tready | tdata: voice_out, parameter_value
//   cfg_    | slave     | cfg_valid/cfg_ready   | cfg_index, cfg_data
//
// A tick makes one read of the depth/scale memory per cycle, with write-back in the
// cycle after each read, then smooths the center.
// An evaluate takes one read per modulator plus the scale,
// a registered multiply and an accumulate. The result register lets the next item in;
// a second evaluate waits at its end while the result is not taken.
// Reset is synchronous; memory entries read as their reset value until first written.
`default_nettype none

module modulated_parameter_smoother import mps_pkg::*; (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_tvalid,
  output logic                in_tready,
  input  logic [IN_TD_W-1:0]  in_tdata,   // [2:0] voice, [5:3] modulator, [21:6] operand_value
  input  logic [OP_W-1:0]     in_tuser,   // [2:0] op
  output logic                out_tvalid,
  input  logic                out_tready,
  output logic [OUT_TD_W-1:0] out_tdata,  // [2:0] voice_out, [18:3] parameter_value
  input  logic                cfg_valid,
  output logic                cfg_ready,
  input  logic [CFG_IW-1:0]   cfg_index,
  input  logic [CFG_DW-1:0]   cfg_data
);

  localparam logic [1:0] ST_IDLE   = 2'd0;
  localparam logic [1:0] ST_TICK   = 2'd1;
  localparam logic [1:0] ST_CENTER = 2'd2;
  localparam logic [1:0] ST_EVAL   = 2'd3;

  logic [1:0] state_r, state_nxt;
  logic [CNT_W-1:0] cnt_r, cnt_nxt;

  logic [OP_W-1:0]  in_op;
  logic [IDX_W-1:0] in_voice;
  logic [IDX_W-1:0] in_mod;
  q14_t             in_val;
  logic             in_acc;
  logic             voice_ok;
  logic             mod_ok;

  logic [ALPHA_W-1:0] alpha_r;
  logic [ALPHA_W-1:0] alpha_eff;
  logic               bipolar_r;
  q14_t               cur_center_r;
  q14_t               tgt_center_r;

  pair_t dep_mem [DEP_ENTRIES];
  q14_t  mod_mem [MOD_ENTRIES];
  logic [DEP_ENTRIES-1:0] dep_vld_r;
  logic [MOD_ENTRIES-1:0] mod_vld_r;

  logic              dep_we;
  logic              dep_we_full;
  logic [DEP_AW-1:0] dep_waddr;
  pair_t             dep_wdata;
  logic [DEP_AW-1:0] dep_raddr;
  pair_t             dep_rdata_r;
  logic              mod_we;
  logic [MOD_AW-1:0] mod_waddr;
  logic [MOD_AW-1:0] mod_raddr;
  q14_t              mod_rdata_r;

  logic [DEP_AW-1:0] wr_depth_addr;
  logic [DEP_AW-1:0] wr_scale_addr;
  logic [IDX_W-1:0]  voice_r;

  logic              s1_vld_r, s1_vld_nxt;
  logic [DEP_AW-1:0] s1_addr_r;
  logic              s1_dvld_r;
  logic              s1_mvld_r;
  logic              s1_is_scale;
  q14_t              s1_cur;
  q14_t              s1_tgt;

  q14_t sm_cur;
  q14_t sm_tgt;
  q14_t sm_out;

  q14_t                       mul_a;
  q14_t                       mul_b;
  logic signed [2*Q_W-1:0]    mul_p;
  logic signed [PROD_W-1:0]   prod_r;
  logic                       s2_vld_r;
  logic signed [ACC_W-1:0]    acc_r;
  logic                       finish;

  logic             out_vld_r;
  logic [IDX_W-1:0] out_voice_r;
  q14_t             out_value_r;

  assign in_op    = in_tuser;
  assign in_voice = in_tdata[2:0];
  assign in_mod   = in_tdata[5:3];
  assign in_val   = $signed(in_tdata[21:6]);

  assign in_tready = (state_r == ST_IDLE);
  assign in_acc    = in_tvalid & in_tready;
  assign voice_ok  = (int'(in_voice) < VOICES);
  assign mod_ok    = (int'(in_mod) < MODULATORS);
  assign cfg_ready = 1'b1;

  assign alpha_eff = (alpha_r > ALPHA_W'(ONE_Q14)) ? ALPHA_W'(ONE_Q14) : alpha_r;

  assign wr_depth_addr = DEP_AW'(in_voice) * DEP_AW'(MODULATORS) + DEP_AW'(in_mod);
  assign wr_scale_addr = DEP_AW'(SCALE_BASE) + DEP_AW'(in_voice);
  assign mod_waddr     = MOD_AW'(in_voice) * MOD_AW'(MODULATORS) + MOD_AW'(in_mod);

  // Stage 1: registered memory word, unwritten entries replaced by their reset value
  assign s1_is_scale = (s1_addr_r >= DEP_AW'(SCALE_BASE));
  assign s1_cur = s1_dvld_r ? dep_rdata_r.cur : (s1_is_scale ? ONE_Q14 : '0);
  assign s1_tgt = s1_dvld_r ? dep_rdata_r.tgt : (s1_is_scale ? ONE_Q14 : '0);

  // Shared smoother: memory entries during the walk, the center at its end
  assign sm_cur = (state_r == ST_CENTER) ? cur_center_r : s1_cur;
  assign sm_tgt = (state_r == ST_CENTER) ? tgt_center_r : s1_tgt;
  assign sm_out = smooth_q14(sm_cur, sm_tgt, alpha_eff);

  // Evaluate multiplier: modulator * depth, or center * scale on the last read
  assign mul_a = s1_is_scale ? cur_center_r : (s1_mvld_r ? mod_rdata_r : '0);
  assign mul_b = s1_cur;
  assign mul_p = mul_a * mul_b;

  assign finish = (state_r == ST_EVAL) && (cnt_r == CNT_W'(MODULATORS + 1)) &&
                  !s1_vld_r && !s2_vld_r && (!out_vld_r || out_tready);

  always_comb begin
    state_nxt   = state_r;
    cnt_nxt     = cnt_r;
    s1_vld_nxt  = 1'b0;
    dep_we      = 1'b0;
    dep_we_full = 1'b0;
    dep_waddr   = wr_depth_addr;
    dep_wdata   = '{tgt: in_val, cur: '0};
    dep_raddr   = cnt_r[DEP_AW-1:0];
    mod_we      = 1'b0;
    mod_raddr   = MOD_AW'(voice_r) * MOD_AW'(MODULATORS) + cnt_r[MOD_AW-1:0];
    case (state_r)
      ST_IDLE: begin
        if (in_acc) begin
          case (in_op)
            OP_MOD_VALUE: begin
              mod_we = voice_ok && mod_ok;
            end
            OP_DEPTH: begin
              dep_we      = voice_ok && mod_ok;
              dep_we_full = !dep_vld_r[wr_depth_addr];
            end
            OP_SCALE: begin
              dep_we      = voice_ok;
              dep_waddr   = wr_scale_addr;
              dep_wdata   = '{tgt: in_val, cur: ONE_Q14};
              dep_we_full = !dep_vld_r[wr_scale_addr];
            end
            OP_TICK: begin
              state_nxt = ST_TICK;
              cnt_nxt   = '0;
            end
            OP_EVAL: begin
              if (voice_ok) begin
                state_nxt = ST_EVAL;
                cnt_nxt   = '0;
              end
            end
            default: ;
          endcase
        end
      end
      ST_TICK: begin
        if (cnt_r != CNT_W'(DEP_ENTRIES)) begin
          s1_vld_nxt = 1'b1;
          cnt_nxt    = cnt_r + 1'b1;
        end else begin
          state_nxt = ST_CENTER;
        end
        // write back the entry read in the previous cycle
        if (s1_vld_r) begin
          dep_we      = 1'b1;
          dep_we_full = 1'b1;
          dep_waddr   = s1_addr_r;
          dep_wdata   = '{tgt: s1_tgt, cur: sm_out};
        end
      end
      ST_CENTER: begin
        state_nxt = ST_IDLE;
      end
      ST_EVAL: begin
        if (cnt_r == CNT_W'(MODULATORS)) begin
          dep_raddr = DEP_AW'(SCALE_BASE) + DEP_AW'(voice_r);
        end else begin
          dep_raddr = DEP_AW'(voice_r) * DEP_AW'(MODULATORS) + cnt_r[DEP_AW-1:0];
        end
        if (cnt_r != CNT_W'(MODULATORS + 1)) begin
          s1_vld_nxt = 1'b1;
          cnt_nxt    = cnt_r + 1'b1;
        end else if (finish) begin
          state_nxt = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (dep_we) begin
      if (dep_we_full) begin
        dep_mem[dep_waddr] <= dep_wdata;
      end else begin
        dep_mem[dep_waddr].tgt <= dep_wdata.tgt;
      end
    end
    dep_rdata_r <= dep_mem[dep_raddr];
    if (mod_we) begin
      mod_mem[mod_waddr] <= in_val;
    end
    mod_rdata_r <= mod_mem[mod_raddr];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      dep_vld_r <= '0;
      mod_vld_r <= '0;
    end else begin
      if (dep_we) begin
        dep_vld_r[dep_waddr] <= 1'b1;
      end
      if (mod_we) begin
        mod_vld_r[mod_waddr] <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r  <= ST_IDLE;
      cnt_r    <= '0;
      s1_vld_r <= 1'b0;
      s2_vld_r <= 1'b0;
    end else begin
      state_r  <= state_nxt;
      cnt_r    <= cnt_nxt;
      s1_vld_r <= s1_vld_nxt;
      s2_vld_r <= s1_vld_r && (state_r == ST_EVAL);
    end
  end

  always_ff @(posedge clk) begin
    s1_addr_r <= dep_raddr;
    s1_dvld_r <= dep_vld_r[dep_raddr];
    s1_mvld_r <= mod_vld_r[mod_raddr];
    prod_r    <= mul_p[2*Q_W-1:14];
    if (in_acc) begin
      voice_r <= in_voice;
      acc_r   <= '0;
    end else if (s2_vld_r) begin
      acc_r <= acc_r + ACC_W'(prod_r);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      alpha_r      <= ALPHA_W'(ONE_Q14);
      bipolar_r    <= 1'b0;
      cur_center_r <= '0;
      tgt_center_r <= '0;
    end else begin
      if (cfg_valid && cfg_ready) begin
        case (cfg_index)
          CFG_ALPHA: begin
            alpha_r <= cfg_data[ALPHA_W-1:0];
          end
          CFG_BIPOLAR: begin
            bipolar_r <= cfg_data[0];
          end
          CFG_DEFAULT: begin
            cur_center_r <= clamp_q14(ACC_W'($signed(cfg_data)), bipolar_r);
            tgt_center_r <= clamp_q14(ACC_W'($signed(cfg_data)), bipolar_r);
          end
          default: ;
        endcase
      end
      if (in_acc && (in_op == OP_CENTER) && voice_ok) begin
        tgt_center_r <= in_val;
      end
      if (state_r == ST_CENTER) begin
        cur_center_r <= sm_out;
      end
    end
  end

  // Output register: hold the result until taken
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_vld_r <= 1'b0;
    end else if (finish) begin
      out_vld_r <= 1'b1;
    end else if (out_tready) begin
      out_vld_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (finish) begin
      out_voice_r <= voice_r;
      out_value_r <= clamp_q14(acc_r, bipolar_r);
    end
  end

  assign out_tvalid = out_vld_r;
  assign out_tdata  = {(OUT_TD_W - Q_W - IDX_W)'(0), out_value_r, out_voice_r};

endmodule

`default_nettype wire

[dv/modulated_parameter_smoother_tb.sv]
// Self-checking testbench for modulated_parameter_smoother: directed and random commands,
// register changes between phases, and an item-level predictor of smoothing and evaluation.
// Depends on mps_pkg and the modulated_parameter_smoother RTL only.
module modulated_parameter_smoother_tb;
  timeunit 1ns;
  timeprecision 1ps;
  import mps_pkg::*;

  localparam logic [OP_W-1:0] OP_SPARE_6 = 3'd6;
  localparam logic [OP_W-1:0] OP_SPARE_7 = 3'd7;
  localparam int SETTLE_CYCLES   = 120;
  localparam int PHASES          = 8;
  localparam int ITEMS_PER_PHASE = 240;

  typedef struct {
    logic [OP_W-1:0]  op;
    logic [IDX_W-1:0] voice;
    logic [IDX_W-1:0] mod_idx;
    q14_t             value;
  } cmd_t;

  typedef struct {
    logic [IDX_W-1:0] voice;
    q14_t             value;
  } param_t;

  logic                clk = 1'b0;
  logic                rst_n = 1'b0;
  logic                in_tvalid = 1'b0;
  logic                in_tready;
  logic [IN_TD_W-1:0]  in_tdata = '0;   // [2:0] voice, [5:3] modulator, [21:6] operand_value
  logic [OP_W-1:0]     in_tuser = '0;   // [2:0] op
  logic                out_tvalid;
  logic                out_tready = 1'b0;
  logic [OUT_TD_W-1:0] out_tdata;       // [2:0] voice_out, [18:3] parameter_value
  logic                cfg_valid = 1'b0;
  logic                cfg_ready;
  logic [CFG_IW-1:0]   cfg_index = '0;
  logic [CFG_DW-1:0]   cfg_data = '0;

  cmd_t   pending_cmds[$];
  param_t expected_params[$];
  int     mismatches = 0;
  bit     steady = 1'b0;
  int     send_gap = 0;
  int     recv_stall = 0;

  // Predicted register and parameter state
  logic [ALPHA_W-1:0] alpha_q;
  logic               bipolar_q;
  q14_t               center_cur;
  q14_t               center_tgt;
  q14_t               scale_cur[VOICES];
  q14_t               scale_tgt[VOICES];
  q14_t               depth_cur[MOD_ENTRIES];
  q14_t               depth_tgt[MOD_ENTRIES];
  q14_t               mod_val[MOD_ENTRIES];

  modulated_parameter_smoother u_top (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .cfg_valid  (cfg_valid),
    .cfg_ready  (cfg_ready),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data)
  );

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (steady || r < 55) return 0;
    if (r < 90) return $urandom_range(1, 3);
    if (r < 98) return $urandom_range(4, 12);
    return $urandom_range(20, 60);
  endfunction

  function automatic q14_t rand_q14();
    int r;
    r = $urandom_range(0, 99);
    if (r < 30) return q14_t'($urandom);
    if (r < 45) begin
      case ($urandom_range(0, 4))
        0: return 16'sh8000;
        1: return 16'sh7fff;
        2: return ONE_Q14;
        3: return -ONE_Q14;
        default: return '0;
      endcase
    end
    return q14_t'(int'($urandom_range(0, 32768)) - 16384);
  endfunction

  function automatic cmd_t rand_cmd();
    cmd_t c;
    int   r;
    r = $urandom_range(0, 99);
    c.voice   = IDX_W'($urandom);
    c.mod_idx = IDX_W'($urandom);
    c.value   = rand_q14();
    if (r < 20) c.op = OP_MOD_VALUE;
    else if (r < 40) c.op = OP_DEPTH;
    else if (r < 50) c.op = OP_SCALE;
    else if (r < 55) c.op = OP_CENTER;
    else if (r < 70) c.op = OP_TICK;
    else if (r < 97) c.op = OP_EVAL;
    else c.op = r[0] ? OP_SPARE_7 : OP_SPARE_6;
    return c;
  endfunction

  function automatic q14_t limit_to_range(longint v);
    longint lo;
    lo = bipolar_q ? -16384 : 0;
    if (v < lo) return q14_t'(lo);
    if (v > 16384) return ONE_Q14;
    return q14_t'(v);
  endfunction

  // Move cur toward tgt by floor(a * (tgt - cur) / 2^14)
  function automatic q14_t glide(q14_t cur, q14_t tgt, longint a);
    longint step;
    step = (longint'(tgt) - longint'(cur)) * a;
    return q14_t'(longint'(cur) + (step >>> 14));
  endfunction

  task automatic reset_prediction();
    alpha_q    = ALPHA_W'(16384);
    bipolar_q  = 1'b0;
    center_cur = '0;
    center_tgt = '0;
    for (int i = 0; i < VOICES; i++) begin
      scale_cur[i] = ONE_Q14;
      scale_tgt[i] = ONE_Q14;
    end
    for (int i = 0; i < MOD_ENTRIES; i++) begin
      depth_cur[i] = '0;
      depth_tgt[i] = '0;
      mod_val[i]   = '0;
    end
  endtask

  task automatic predict_reg(logic [CFG_IW-1:0] idx, logic [CFG_DW-1:0] data);
    case (idx)
      CFG_ALPHA: alpha_q = data[ALPHA_W-1:0];
      CFG_BIPOLAR: bipolar_q = data[0];
      CFG_DEFAULT: begin
        center_cur = limit_to_range(longint'(q14_t'(data)));
        center_tgt = center_cur;
      end
      default: ;
    endcase
  endtask

  task automatic predict_cmd(cmd_t c);
    int     k;
    longint a;
    longint acc;
    param_t p;
    k = int'(c.voice) * MODULATORS + int'(c.mod_idx);
    case (c.op)
      OP_MOD_VALUE: mod_val[k] = c.value;
      OP_DEPTH: depth_tgt[k] = c.value;
      OP_SCALE: scale_tgt[c.voice] = c.value;
      OP_CENTER: center_tgt = c.value;
      OP_TICK: begin
        // alpha above one behaves as one
        a = (alpha_q > 16384) ? 16384 : longint'(alpha_q);
        center_cur = glide(center_cur, center_tgt, a);
        for (int i = 0; i < VOICES; i++) scale_cur[i] = glide(scale_cur[i], scale_tgt[i], a);
        for (int i = 0; i < MOD_ENTRIES; i++) depth_cur[i] = glide(depth_cur[i], depth_tgt[i], a);
      end
      OP_EVAL: begin
        acc = (longint'(center_cur) * longint'(scale_cur[c.voice])) >>> 14;
        for (int m = 0; m < MODULATORS; m++) begin
          k = int'(c.voice) * MODULATORS + m;
          acc += (longint'(mod_val[k]) * longint'(depth_cur[k])) >>> 14;
        end
        if (acc > 32767) acc = 32767;
        if (acc < -32768) acc = -32768;
        p.voice = c.voice;
        p.value = limit_to_range(acc);
        expected_params.insert(expected_params.size(), p);
      end
      default: ;
    endcase
  endtask

  task automatic push_cmd(logic [OP_W-1:0] op, int voice, int mod_idx, q14_t value);
    cmd_t c;
    c.op      = op;
    c.voice   = IDX_W'(voice);
    c.mod_idx = IDX_W'(mod_idx);
    c.value   = value;
    pending_cmds.insert(pending_cmds.size(), c);
  endtask

  task automatic write_reg(logic [CFG_IW-1:0] idx, logic [CFG_DW-1:0] data);
    @(posedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
  endtask

  // Wait for the sender to drain and every result to arrive, then let a tick finish
  task automatic settle();
    while (pending_cmds.size() != 0 || in_tvalid || expected_params.size() != 0)
      @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  // Track accepted items and register writes
  always @(posedge clk) begin : prediction_update
    cmd_t seen;
    if (rst_n) begin
      if (cfg_valid && cfg_ready) predict_reg(cfg_index, cfg_data);
      if (in_tvalid && in_tready) begin
        seen.op      = in_tuser;
        seen.voice   = in_tdata[IDX_W-1:0];
        seen.mod_idx = in_tdata[IDX_W +: IDX_W];
        seen.value   = in_tdata[2*IDX_W +: Q_W];
        predict_cmd(seen);
      end
    end
  end

  always @(posedge clk) begin : cmd_driver
    cmd_t c;
    if (!rst_n) begin
      in_tvalid <= 1'b0;
    end else if (in_tvalid && !in_tready) begin
      // hold the item until it is taken
    end else if (send_gap > 0) begin
      send_gap = send_gap - 1;
      in_tvalid <= 1'b0;
    end else if (pending_cmds.size() > 0) begin
      c = pending_cmds.pop_front();
      in_tvalid <= 1'b1;
      in_tuser  <= c.op;
      in_tdata  <= IN_TD_W'({c.value, c.mod_idx, c.voice});
      send_gap = pick_gap();
    end else begin
      in_tvalid <= 1'b0;
    end
  end

  always @(posedge clk) begin : result_backpressure
    if (recv_stall > 0) begin
      out_tready <= 1'b0;
      recv_stall = recv_stall - 1;
    end else begin
      out_tready <= 1'b1;
      if ($urandom_range(0, 3) == 0) recv_stall = pick_gap();
    end
  end

  always @(posedge clk) begin : result_check
    param_t           want;
    logic [IDX_W-1:0] got_voice;
    q14_t             got_value;
    if (rst_n && out_tvalid && out_tready) begin
      got_voice = out_tdata[IDX_W-1:0];
      got_value = out_tdata[IDX_W +: Q_W];
      if (expected_params.size() == 0) begin
        $display("%0t: result with nothing expected: voice %0d value %0d",
                 $time, got_voice, got_value);
        mismatches++;
      end else begin
        want = expected_params.pop_front();
        if (got_voice !== want.voice) begin
          $display("%0t: voice_out expected %0d actual %0d", $time, want.voice, got_voice);
          mismatches++;
        end
        if (got_value !== want.value) begin
          $display("%0t: parameter_value for voice %0d expected %0d actual %0d",
                   $time, want.voice, want.value, got_value);
          mismatches++;
        end
      end
    end
  end

  initial begin
    reset_prediction();
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;
    for (int ph = 0; ph < PHASES; ph++) begin
      if (ph > 0) settle();
      steady = (ph % 3 == 2);
      case (ph)
        0: begin
          // reset state, full-scale products, negative sums, spare ops
          push_cmd(OP_EVAL, 0, 0, '0);
          push_cmd(OP_MOD_VALUE, 7, 7, 16'sh7fff);
          push_cmd(OP_DEPTH, 7, 7, 16'sh7fff);
          push_cmd(OP_EVAL, 7, 0, '0);
          push_cmd(OP_TICK, 0, 0, '0);
          push_cmd(OP_EVAL, 7, 7, '0);
          push_cmd(OP_MOD_VALUE, 0, 0, 16'sh8000);
          push_cmd(OP_DEPTH, 0, 0, 16'sh7fff);
          push_cmd(OP_TICK, 7, 7, 16'sh7fff);
          push_cmd(OP_EVAL, 0, 7, '0);
          push_cmd(OP_SCALE, 3, 0, 16'sh8000);
          push_cmd(OP_CENTER, 3, 0, 16'sh7fff);
          push_cmd(OP_TICK, 0, 0, '0);
          push_cmd(OP_EVAL, 3, 0, '0);
          push_cmd(OP_SPARE_6, 7, 7, -16'sd1);
          push_cmd(OP_SPARE_7, 0, 0, '0);
          push_cmd(OP_DEPTH, 7, 7, 16'sh8000);
          push_cmd(OP_TICK, 0, 0, '0);
          push_cmd(OP_EVAL, 7, 0, '0);
          push_cmd(OP_CENTER, 0, 0, 16'sd8192);
          push_cmd(OP_SCALE, 5, 0, ONE_Q14);
          push_cmd(OP_TICK, 0, 0, '0);
          push_cmd(OP_EVAL, 5, 0, '0);
        end
        1: begin
          write_reg(CFG_ALPHA, 16'd16384);
          write_reg(CFG_BIPOLAR, 16'd1);
          write_reg(CFG_DEFAULT, 16'hc000);
        end
        2: write_reg(CFG_ALPHA, 16'd0);
        3: begin
          write_reg(CFG_ALPHA, 16'h7fff);
          write_reg(CFG_DEFAULT, 16'h7fff);
        end
        4: begin
          write_reg(CFG_ALPHA, 16'd1);
          write_reg(CFG_BIPOLAR, 16'd0);
          write_reg(CFG_DEFAULT, 16'h8000);
        end
        5: begin
          write_reg(CFG_ALPHA, CFG_DW'($urandom_range(0, 16384)));
          write_reg(CFG_DEFAULT, CFG_DW'($urandom));
        end
        6: begin
          write_reg(CFG_ALPHA, 16'd8192);
          write_reg(CFG_BIPOLAR, 16'd1);
          write_reg(CFG_DEFAULT, CFG_DW'($urandom));
        end
        default: begin
          write_reg(CFG_ALPHA, CFG_DW'($urandom_range(16385, 32767)));
          write_reg(CFG_BIPOLAR, 16'd0);
          write_reg(CFG_DEFAULT, CFG_DW'($urandom_range(0, 16384)));
        end
      endcase
      repeat (ITEMS_PER_PHASE) pending_cmds.insert(pending_cmds.size(), rand_cmd());
    end
    settle();
    if (mismatches == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

  initial begin
    #4_000_000;
    $display("FAIL");
    $finish;
  end

endmodule
